// ===== hw/rtl/jfd_pkg.sv =====
// Shared types and constants for the FIFO job dispatcher.
// No dependencies; used by every file under hw/rtl.
package jfd_pkg;

    localparam int ID_W       = 31;
    localparam int TIME_W     = 32;
    localparam int LIMIT_W    = 3;
    localparam int WAIT_DEPTH = 4;
    // Wait limit after reset.
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;
    // At most four results per transaction, so at most three jobs may wait.
    localparam int RESULT_CAP = 3;

    localparam logic OUTCOME_DONE  = 1'b0;
    localparam logic OUTCOME_ABORT = 1'b1;

    // One waiting job, as held by a queue cell.
    typedef struct packed {
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] arrival;
        logic [ID_W-1:0] duration;
        logic [ID_W-1:0] deadline;
    } job_t;

    // Outcome of resolving the head job at the current server time.
    typedef struct packed {
        logic              outcome;
        logic [TIME_W-1:0] event_time;
        logic [TIME_W-1:0] delay;
        logic [TIME_W-1:0] busy_next;
    } res_t;

endpackage

// ===== hw/rtl/fifo_job_dispatch_with_timeout_top.sv =====
// Top level of the single-server FIFO job dispatcher with deadline abort.
// Depends on jfd_pkg, jfd_cell and jfd_resolve.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  config  | cfg_valid, cfg_ready, cfg_data                 | in
//  jobs    | in_valid, in_ready, job_id, arrival, duration, | in
//          | deadline, last_job                             |
//  results | out_valid, out_ready, done_job, outcome,       | out
//          | event_time, delay, end_of_run                  |
//
// A job transaction is accepted in S_IDLE; S_RESOLVE then resolves each waiting job
// now due (up to three) until no further job is due, and S_ADMIT admits the new job.
// After a job flagged last, S_DRAIN resolves each queued job in turn to drain the queue.
// Results leave one per cycle through a single output register; a stall on the
// results channel holds the sequencer in place.
// Reset clears the sequencer, server time, queue count and wait limit (3), not the cells.
module fifo_job_dispatch_with_timeout_top
#(
    parameter int WAIT_DEPTH = jfd_pkg::WAIT_DEPTH
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [jfd_pkg::LIMIT_W-1:0] cfg_data,
    // job input
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [jfd_pkg::ID_W-1:0]    job_id,
    input  logic [jfd_pkg::ID_W-1:0]    arrival,
    input  logic [jfd_pkg::ID_W-1:0]    duration,
    input  logic [jfd_pkg::ID_W-1:0]    deadline,
    input  logic                        last_job,
    // result output
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [jfd_pkg::ID_W-1:0]    done_job,
    output logic                        outcome,
    output logic [jfd_pkg::TIME_W-1:0]  event_time,
    output logic [jfd_pkg::TIME_W-1:0]  delay,
    output logic                        end_of_run
);

    localparam int CW   = $clog2(WAIT_DEPTH + 1);
    // Usable queue places: bounded by the cells and by the result slots.
    localparam int CAP  = (WAIT_DEPTH < jfd_pkg::RESULT_CAP) ? WAIT_DEPTH
                                                              : jfd_pkg::RESULT_CAP;
    localparam int CMPW = (CW > jfd_pkg::LIMIT_W) ? CW : jfd_pkg::LIMIT_W;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_RESOLVE = 4'b0010,
        S_ADMIT   = 4'b0100,
        S_DRAIN   = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [jfd_pkg::LIMIT_W-1:0] limit_reg;
    logic [jfd_pkg::TIME_W-1:0]  busy_reg, busy_next;
    logic [CW-1:0]               count_reg, count_next;
    jfd_pkg::job_t               job_reg;
    logic                        last_reg;

    logic                        out_valid_reg;
    logic [jfd_pkg::ID_W-1:0]    done_job_reg;
    logic                        outcome_reg;
    logic [jfd_pkg::TIME_W-1:0]  event_time_reg;
    logic [jfd_pkg::TIME_W-1:0]  delay_reg;
    logic                        end_of_run_reg;

    // sequencer outputs for this cycle
    logic                        emit;
    logic [jfd_pkg::ID_W-1:0]    emit_id;
    logic                        emit_outcome;
    logic [jfd_pkg::TIME_W-1:0]  emit_time;
    logic [jfd_pkg::TIME_W-1:0]  emit_delay;
    logic                        emit_eor;
    logic                        pop;
    logic                        push;

    logic                        in_fire;
    logic                        slot_free;
    logic                        arrived;
    logic                        room;
    logic [jfd_pkg::LIMIT_W-1:0] eff_limit;
    logic [jfd_pkg::TIME_W-1:0]  start_finish;

    jfd_pkg::job_t               in_job;
    jfd_pkg::job_t               cell_q [WAIT_DEPTH];
    jfd_pkg::res_t               head_res;

    //------------------------------------------------------------------
    // Configuration: always ready; to be only written while idle, which the block does not enforce.
    //------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= jfd_pkg::LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    //------------------------------------------------------------------
    // Job capture: hold the accepted job for the whole sequence.
    //------------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign in_job.id       = job_id;
    assign in_job.arrival  = arrival;
    assign in_job.duration = duration;
    assign in_job.deadline = deadline;

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            job_reg  <= in_job;
            last_reg <= last_job;
        end
    end

    //------------------------------------------------------------------
    // Wait queue: a chain of cells, head in cell 0. A pop shifts every
    // cell one place towards the head; a push loads the cell at count.
    //------------------------------------------------------------------
    for (genvar i = 0; i < WAIT_DEPTH; i++)
    begin : g_cell
        jfd_pkg::job_t nb;
        logic          load;

        if (i == WAIT_DEPTH - 1)
        begin : g_tail
            assign nb = cell_q[i];
        end
        else
        begin : g_link
            assign nb = cell_q[i+1];
        end

        assign load = push && (count_reg == CW'(i));

        jfd_cell u_cell
        (
            .clk       (clk),
            .shift_en  (pop),
            .load_en   (load),
            .neighbour (nb),
            .new_job   (job_reg),
            .job       (cell_q[i])
        );
    end

    jfd_resolve u_resolve
    (
        .busy (busy_reg),
        .head (cell_q[0]),
        .res  (head_res)
    );

    //------------------------------------------------------------------
    // Sequencer
    //------------------------------------------------------------------
    assign slot_free    = !out_valid_reg || out_ready;
    assign arrived      = ({1'b0, job_reg.arrival} >= busy_reg);
    assign eff_limit    = (limit_reg > jfd_pkg::LIMIT_W'(CAP)) ? jfd_pkg::LIMIT_W'(CAP)
                                                                : limit_reg;
    assign room         = (CMPW'(count_reg) < CMPW'(eff_limit));
    assign start_finish = {1'b0, job_reg.arrival} + {1'b0, job_reg.duration};

    always_comb
    begin
        state_next   = state_reg;
        busy_next    = busy_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        emit_id      = cell_q[0].id;
        emit_outcome = head_res.outcome;
        emit_time    = head_res.event_time;
        emit_delay   = head_res.delay;
        emit_eor     = 1'b0;
        pop          = 1'b0;
        push         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_RESOLVE;
                end
            end

            S_RESOLVE:
            begin
                // Resolve every waiting job whose turn comes by this arrival.
                if (count_reg != '0 && arrived)
                begin
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        pop        = 1'b1;
                        count_next = count_reg - CW'(1);
                        busy_next  = head_res.busy_next;
                    end
                end
                else
                begin
                    state_next = S_ADMIT;
                end
            end

            S_ADMIT:
            begin
                emit_id = job_reg.id;
                if (count_reg == '0 && arrived)
                begin
                    // Idle server: start at once.
                    emit_outcome = jfd_pkg::OUTCOME_DONE;
                    emit_time    = start_finish;
                    emit_delay   = '0;
                    emit_eor     = last_reg;
                    if (slot_free)
                    begin
                        emit       = 1'b1;
                        busy_next  = last_reg ? '0 : start_finish;
                        state_next = S_IDLE;
                    end
                end
                else if (room)
                begin
                    push       = 1'b1;
                    count_next = count_reg + CW'(1);
                    state_next = last_reg ? S_DRAIN : S_IDLE;
                end
                else
                begin
                    // Queue full: abort at arrival.
                    emit_outcome = jfd_pkg::OUTCOME_ABORT;
                    emit_time    = {1'b0, job_reg.arrival};
                    emit_delay   = '0;
                    emit_eor     = last_reg && (count_reg == '0);
                    if (slot_free)
                    begin
                        emit = 1'b1;
                        if (last_reg && count_reg != '0)
                        begin
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            busy_next  = last_reg ? '0 : busy_reg;
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            S_DRAIN:
            begin
                emit_eor = (count_reg == CW'(1));
                if (slot_free)
                begin
                    emit       = 1'b1;
                    pop        = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (count_reg == CW'(1))
                    begin
                        busy_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        busy_next = head_res.busy_next;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    //------------------------------------------------------------------
    // Output register: load on emit, drop once the transaction is taken.
    //------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            done_job_reg   <= emit_id;
            outcome_reg    <= emit_outcome;
            event_time_reg <= emit_time;
            delay_reg      <= emit_delay;
            end_of_run_reg <= emit_eor;
        end
    end

    assign out_valid  = out_valid_reg;
    assign done_job   = done_job_reg;
    assign outcome    = outcome_reg;
    assign event_time = event_time_reg;
    assign delay      = delay_reg;
    assign end_of_run = end_of_run_reg;

    //------------------------------------------------------------------
    // Assertions
    //------------------------------------------------------------------
    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAP))
        else $error("wait queue holds more jobs than the usable places");

    a_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && pop))
        else $error("queue push and pop in the same cycle");

    a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result emitted over a pending transaction");

    a_run_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_eor) |=> (count_reg == '0 && busy_reg == '0 && state_reg == S_IDLE))
        else $error("state not back to reset after end of run");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from an empty wait queue");

endmodule

// ===== hw/rtl/jfd_cell.sv =====
// One cell of the shifting wait queue: holds a job, loads a new one or
// takes its neighbour's job on a pop. Depends on jfd_pkg.
module jfd_cell
(
    input  logic          clk,
    input  logic          shift_en,
    input  logic          load_en,
    input  jfd_pkg::job_t neighbour,
    input  jfd_pkg::job_t new_job,
    output jfd_pkg::job_t job
);

    jfd_pkg::job_t job_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            job_reg <= neighbour;
        end
        else if (load_en)
        begin
            job_reg <= new_job;
        end
    end

    assign job = job_reg;

endmodule

// ===== hw/rtl/jfd_resolve.sv =====
// Resolves the head of the wait queue against the server time:
// complete, abort at once, or abort at the deadline. Depends on jfd_pkg.
module jfd_resolve
(
    input  logic [jfd_pkg::TIME_W-1:0] busy,
    input  jfd_pkg::job_t              head,
    output jfd_pkg::res_t              res
);

    logic [jfd_pkg::TIME_W-1:0] arr32;
    logic [jfd_pkg::TIME_W-1:0] dl32;
    logic [jfd_pkg::TIME_W:0]   finish;
    logic [jfd_pkg::TIME_W-1:0] wait_delay;
    logic [jfd_pkg::TIME_W-1:0] late_delay;

    assign arr32  = {1'b0, head.arrival};
    assign dl32   = {1'b0, head.deadline};
    assign finish = {1'b0, busy} + {2'b00, head.duration};

    // Clamp negative waits to zero.
    assign wait_delay = (busy > arr32) ? (busy - arr32) : '0;
    assign late_delay = (dl32 > arr32) ? (dl32 - arr32) : '0;

    always_comb
    begin
        if (dl32 <= busy)
        begin
            res.outcome    = jfd_pkg::OUTCOME_ABORT;
            res.event_time = busy;
            res.delay      = wait_delay;
            res.busy_next  = busy;
        end
        else if (finish <= {1'b0, dl32})
        begin
            res.outcome    = jfd_pkg::OUTCOME_DONE;
            res.event_time = finish[jfd_pkg::TIME_W-1:0];
            res.delay      = wait_delay;
            res.busy_next  = finish[jfd_pkg::TIME_W-1:0];
        end
        else
        begin
            res.outcome    = jfd_pkg::OUTCOME_ABORT;
            res.event_time = dl32;
            res.delay      = late_delay;
            res.busy_next  = dl32;
        end
    end

endmodule
